// File: hw/rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// types and constants shared by the move-to-front list and its cells
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned RSP_WIDTH    = 8;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_APPENDED = 2'd0,
      STATUS_FOUND    = 2'd1,
      STATUS_MISSING  = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic                   append;
      logic                   found;
      logic [VALUE_WIDTH-1:0] key;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/mtf_cell.sv
// ----------------------------------------------------------------------------
// mtf_cell
// one list position: holds an entry, compares it to the key, passes the hit
// flag down the row; takes the key on tail append, its front entry on a move
// ----------------------------------------------------------------------------
module mtf_cell (
   input  logic                               clock,
   input  mtf_pkg::cell_ctrl_type             ctrl,
   input  logic                               valid,
   input  logic                               is_tail,
   input  logic [mtf_pkg::VALUE_WIDTH-1:0]    prev_entry,
   input  logic                               hit_in,
   output logic                               hit_out,
   output logic [mtf_pkg::VALUE_WIDTH-1:0]    entry
);

   logic [mtf_pkg::VALUE_WIDTH-1:0] entry_ff;
   logic [mtf_pkg::VALUE_WIDTH-1:0] entry_in;
   logic                            match;

   assign match   = valid && (entry_ff == ctrl.key);
   assign hit_out = hit_in || match;
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append && is_tail) begin
         entry_in = ctrl.key;
      end else if (ctrl.found && !hit_in) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hw/rtl/move_to_front_list.sv
// a result is registered in the cycle after its request transaction
// throughput: one request per cycle; all cells compare and shift in parallel,
//   the row's hit chain settles within that cycle
// a pending result does not block the next request unless rsp_tready is low
// reset: synchronous, clears the entry count and the response valid flag;
//   entries and the registered status are not cleared
// ----------------------------------------------------------------------------
// move_to_front_list
// self-organizing list with move-to-front search and tail append
// ----------------------------------------------------------------------------
module move_to_front_list #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mtf_pkg::VALUE_WIDTH-1:0]   req_tdata,  // item_value
   input  logic [0:0]                        req_tuser,  // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mtf_pkg::RSP_WIDTH-1:0]     rsp_tdata   // status, zero pad
);

   localparam int unsigned COUNT_WIDTH = $clog2(CAPACITY + 1);

   logic [COUNT_WIDTH-1:0]          count_ff;
   logic [COUNT_WIDTH-1:0]          count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   mtf_pkg::status_type             rsp_status_ff;
   mtf_pkg::status_type             rsp_status_in;

   logic                            req_accept;
   logic                            is_search;
   logic                            is_full;
   logic                            hit_any;
   mtf_pkg::cell_ctrl_type          ctrl;
   logic                            hit [CAPACITY+1];
   logic [mtf_pkg::VALUE_WIDTH-1:0] entry [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign is_search  = (req_tuser[0] == mtf_pkg::OP_SEARCH);
   assign is_full    = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign hit_any    = hit[CAPACITY];

   assign ctrl.append = req_accept && !is_search && !is_full;
   assign ctrl.found  = req_accept && is_search && hit_any;
   assign ctrl.key    = req_tdata;

   assign hit[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [mtf_pkg::VALUE_WIDTH-1:0] prev;
      if (i == 0) begin : g_front
         assign prev = req_tdata;
      end else begin : g_rest
         assign prev = entry[i-1];
      end
      mtf_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (COUNT_WIDTH'(i) < count_ff),
         .is_tail    (COUNT_WIDTH'(i) == count_ff),
         .prev_entry (prev),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .entry      (entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.append) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         if (is_search) begin
            rsp_status_in = hit_any ? mtf_pkg::STATUS_FOUND : mtf_pkg::STATUS_MISSING;
         end else begin
            rsp_status_in = is_full ? mtf_pkg::STATUS_FULL : mtf_pkg::STATUS_APPENDED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mtf_pkg::RSP_WIDTH - mtf_pkg::STATUS_WIDTH){1'b0}}, rsp_status_ff};

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count above capacity");

   a_append_ok : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_search && !is_full) |=>
         (rsp_status_ff == mtf_pkg::STATUS_APPENDED && count_ff == $past(count_ff) + 1'b1))
      else $error("append to non-full list not taken");

   a_found_front : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_search && hit_any) |=> (entry[0] == $past(req_tdata)))
      else $error("found key not at front");

   a_search_count : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_search) |=> $stable(count_ff))
      else $error("search changed entry count");

endmodule
